// ----- sv/timespec_arithmetic_unit_assert.svh -----
// Assertion macros used by the timestamp arithmetic unit.
`ifndef TIMESPEC_ARITHMETIC_UNIT_ASSERT_SVH
`define TIMESPEC_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSAU_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("timespec unit check failed");

// Next-cycle implication, disabled during reset.
`define TSAU_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("timespec unit check failed");

`endif

// ----- sv/tsau_pkg.sv -----
// Operation codes, status codes, constants and the divider step of the timestamp unit.
package tsau_pkg;

  typedef enum logic [3:0] {
    FN_GT      = 4'd0,
    FN_LT      = 4'd1,
    FN_EQ      = 4'd2,
    FN_SUB     = 4'd3,
    FN_ADD     = 4'd4,
    FN_DIV     = 4'd5,
    FN_MUL     = 4'd6,
    FN_TO_MS   = 4'd7,
    FN_TO_US   = 4'd8,
    FN_TO_NS   = 4'd9,
    FN_FROM_MS = 4'd10,
    FN_FROM_US = 4'd11,
    FN_FROM_NS = 4'd12
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_ZDIV = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  localparam logic [29:0] NS_MAX = 30'd999999999;
  localparam logic [29:0] ONE_E9 = 30'd1000000000;
  localparam logic [29:0] ONE_E6 = 30'd1000000;
  localparam logic [29:0] ONE_E3 = 30'd1000;
  localparam logic [29:0] ONE    = 30'd1;

  // Reciprocals for exact division of a 30-bit value by 1e6 and 1e3.
  localparam logic [30:0] RECIP_E6 = 31'd1125899907;
  localparam int          SHIFT_E6 = 50;
  localparam logic [30:0] RECIP_E3 = 31'd274877907;
  localparam int          SHIFT_E3 = 38;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] dvd;
  } dstep_t;

  // One restoring division step: the top dividend bit enters the remainder and
  // the quotient bit enters the dividend register from below.
  function automatic dstep_t div_step(input logic [31:0] rem, input logic [63:0] dvd,
                                      input logic [31:0] dvs);
    logic [32:0] t;
    logic        ge;
    dstep_t      r;
    t     = {rem, dvd[63]};
    ge    = (t >= {1'b0, dvs});
    r.rem = ge ? 32'(t - {1'b0, dvs}) : t[31:0];
    r.dvd = {dvd[62:0], ge};
    return r;
  endfunction

endpackage

// ----- sv/timespec_arithmetic_unit.sv -----
// Timestamp arithmetic unit: compare, sub, add, div, mul and count conversions.
// A word passes s0, s1, w[0], the first divider, w[IDX_M], the second divider and w[IDX_OUT].
// Throughput: one word per cycle unless stalled; the depth is set by the long-division chain of
// 64 steps for the first quotient and 30 steps for the nanosecond quotient.
// A stall on the master side holds every stage; a skid register keeps s_tready registered.
// Reset (rst, synchronous) clears the valid flags only, skid_v among them.
`include "timespec_arithmetic_unit_assert.svh"

module timespec_arithmetic_unit #(
  parameter int SEC_BITS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // func, a_sec, a_nsec, b_sec, b_nsec, factor, count (from bit 0 up), zero padded.
  input  logic [((2*SEC_BITS+167)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // res_sec, res_nsec, res_count, verdict, status (from bit 0 up), zero padded.
  output logic [((SEC_BITS+104)/8)*8-1:0] m_tdata
);

  localparam int OUT_W     = ((SEC_BITS+104)/8)*8;
  localparam int A_SEC_LO  = 4;
  localparam int A_NSEC_LO = A_SEC_LO + SEC_BITS;
  localparam int B_SEC_LO  = A_NSEC_LO + 30;
  localparam int B_NSEC_LO = B_SEC_LO + SEC_BITS;
  localparam int FAC_LO    = B_NSEC_LO + 30;
  localparam int CNT_LO    = FAC_LO + 32;
  localparam int LO_W      = SEC_BITS/2;
  localparam int HI_W      = SEC_BITS - LO_W;
  localparam int CW        = (SEC_BITS + 31 > 65) ? SEC_BITS + 31 : 65;
  localparam int MW        = SEC_BITS + 33;
  localparam int P1        = 64;
  localparam int P2        = 30;
  localparam int IDX_M     = P1 + 1;
  localparam int IDX_OUT   = P1 + P2 + 2;
  localparam int NW        = IDX_OUT + 1;

  typedef struct packed {
    logic [3:0]          func;
    logic [SEC_BITS-1:0] a_sec;
    logic [29:0]         a_nsec;
    logic [SEC_BITS-1:0] b_sec;
    logic [29:0]         b_nsec;
    logic [31:0]         factor;
    logic [63:0]         count;
  } in_t;

  typedef struct packed {
    logic [3:0]          func;
    logic [SEC_BITS-1:0] as;
    logic [29:0]         an;
    logic [31:0]         fac;
    logic [63:0]         cnt;
    logic                vd;
    logic [1:0]          st;
    logic [SEC_BITS-1:0] rs;
    logic [29:0]         rn;
    logic [61:0]         prod;
    logic [LO_W+31:0]    pf_lo;
    logic [HI_W+31:0]    pf_hi;
    logic [LO_W+29:0]    tc_lo;
    logic [HI_W+29:0]    tc_hi;
    logic [29:0]         part;
  } s1_t;

  typedef struct packed {
    logic [3:0]           func;
    logic [29:0]          an;
    logic [SEC_BITS+31:0] asfac;
    logic [SEC_BITS-1:0]  rs;
    logic [29:0]          rn;
    logic [63:0]          rc;
    logic                 vd;
    logic [1:0]           st;
    logic [63:0]          dvd;
    logic [31:0]          dvs;
    logic [31:0]          rem;
  } work_t;

  function automatic work_t work_step(input work_t x);
    tsau_pkg::dstep_t d;
    work_t            y;
    d     = tsau_pkg::div_step(x.rem, x.dvd, x.dvs);
    y     = x;
    y.rem = d.rem;
    y.dvd = d.dvd;
    return y;
  endfunction

  in_t   bus_word, skid, in_word, in_sat, s0;
  logic  skid_v, in_v, v0, v1, adv;
  s1_t   s1, s1_next;
  work_t w [0:NW-1];
  work_t w0_next, wm_next, wout_next, w_out;
  logic [NW-1:0] wv;
  logic  out_is_cmp, out_zero_ts;

  assign bus_word.func   = s_tdata[3:0];
  assign bus_word.a_sec  = s_tdata[A_SEC_LO +: SEC_BITS];
  assign bus_word.a_nsec = s_tdata[A_NSEC_LO +: 30];
  assign bus_word.b_sec  = s_tdata[B_SEC_LO +: SEC_BITS];
  assign bus_word.b_nsec = s_tdata[B_NSEC_LO +: 30];
  assign bus_word.factor = s_tdata[FAC_LO +: 32];
  assign bus_word.count  = s_tdata[CNT_LO +: 64];

  assign adv      = !wv[IDX_OUT] || m_tready;
  assign s_tready = !skid_v;
  assign in_v     = skid_v || s_tvalid;
  assign in_word  = skid_v ? skid : bus_word;

  // A word that arrives while the pipeline is held waits in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (adv) begin
      skid_v <= 1'b0;
    end else if (s_tvalid && !skid_v) begin
      skid_v <= 1'b1;
    end
    if (!skid_v) begin
      skid <= bus_word;
    end
  end

  // Stage 0: nanosecond saturation.
  always_comb begin
    in_sat        = in_word;
    in_sat.a_nsec = (in_word.a_nsec > tsau_pkg::NS_MAX) ? tsau_pkg::NS_MAX : in_word.a_nsec;
    in_sat.b_nsec = (in_word.b_nsec > tsau_pkg::NS_MAX) ? tsau_pkg::NS_MAX : in_word.b_nsec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_v;
    end
    if (adv) begin
      s0 <= in_sat;
    end
  end

  // Stage 1: compare, sub, add, the partial products and the nanosecond part of the to-count conversions.
  always_comb begin
    logic                gt, lt, eq, borrow, nc;
    logic [30:0]         nsum;
    logic [SEC_BITS:0]   ssum;
    logic [60:0]         r6, r3;
    logic [29:0]         per;
    s1_next      = '0;
    s1_next.func = s0.func;
    s1_next.as   = s0.a_sec;
    s1_next.an   = s0.a_nsec;
    s1_next.fac  = s0.factor;
    s1_next.cnt  = s0.count;
    gt     = (s0.a_sec > s0.b_sec) || (s0.a_sec == s0.b_sec && s0.a_nsec > s0.b_nsec);
    lt     = (s0.a_sec < s0.b_sec) || (s0.a_sec == s0.b_sec && s0.a_nsec < s0.b_nsec);
    eq     = (s0.a_sec == s0.b_sec) && (s0.a_nsec == s0.b_nsec);
    borrow = s0.b_nsec > s0.a_nsec;
    nsum   = 31'(s0.a_nsec) + 31'(s0.b_nsec);
    nc     = nsum >= 31'(tsau_pkg::ONE_E9);
    ssum   = (SEC_BITS+1)'(s0.a_sec) + (SEC_BITS+1)'(s0.b_sec) + (SEC_BITS+1)'(nc);
    r6     = 61'(s0.a_nsec) * 61'(tsau_pkg::RECIP_E6);
    r3     = 61'(s0.a_nsec) * 61'(tsau_pkg::RECIP_E3);
    per    = '0;
    case (s0.func)
      tsau_pkg::FN_GT: s1_next.vd = gt;
      tsau_pkg::FN_LT: s1_next.vd = lt;
      tsau_pkg::FN_EQ: s1_next.vd = eq;
      tsau_pkg::FN_SUB: begin
        s1_next.st = lt ? tsau_pkg::ST_NEG : tsau_pkg::ST_OK;
        s1_next.rs = s0.a_sec - s0.b_sec - SEC_BITS'(borrow);
        s1_next.rn = borrow ? 30'(31'(tsau_pkg::ONE_E9) + 31'(s0.a_nsec) - 31'(s0.b_nsec))
                            : s0.a_nsec - s0.b_nsec;
      end
      tsau_pkg::FN_ADD: begin
        s1_next.rn = nc ? 30'(nsum - 31'(tsau_pkg::ONE_E9)) : nsum[29:0];
        s1_next.rs = ssum[SEC_BITS-1:0];
        s1_next.st = ssum[SEC_BITS] ? tsau_pkg::ST_OVF : tsau_pkg::ST_OK;
      end
      tsau_pkg::FN_TO_MS: begin
        per          = tsau_pkg::ONE_E3;
        s1_next.part = 30'(r6 >> tsau_pkg::SHIFT_E6);
      end
      tsau_pkg::FN_TO_US: begin
        per          = tsau_pkg::ONE_E6;
        s1_next.part = 30'(r3 >> tsau_pkg::SHIFT_E3);
      end
      tsau_pkg::FN_TO_NS: begin
        per          = tsau_pkg::ONE_E9;
        s1_next.part = s0.a_nsec;
      end
      default: ;
    endcase
    s1_next.prod  = 62'(s0.a_nsec) * 62'(s0.factor);
    s1_next.pf_lo = (LO_W+32)'(s0.a_sec[LO_W-1:0]) * (LO_W+32)'(s0.factor);
    s1_next.pf_hi = (HI_W+32)'(s0.a_sec[SEC_BITS-1:LO_W]) * (HI_W+32)'(s0.factor);
    s1_next.tc_lo = (LO_W+30)'(s0.a_sec[LO_W-1:0]) * (LO_W+30)'(per);
    s1_next.tc_hi = (HI_W+30)'(s0.a_sec[SEC_BITS-1:LO_W]) * (HI_W+30)'(per);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: product sums, to-count results and the divider setup.
  always_comb begin
    logic [CW-1:0] full;
    w0_next      = '0;
    w0_next.func = s1.func;
    w0_next.an   = s1.an;
    w0_next.vd   = s1.vd;
    w0_next.st   = s1.st;
    w0_next.rs   = s1.rs;
    w0_next.rn   = s1.rn;
    w0_next.asfac = ((SEC_BITS+32)'(s1.pf_hi) << LO_W) + (SEC_BITS+32)'(s1.pf_lo);
    full = (CW'(s1.tc_hi) << LO_W) + CW'(s1.tc_lo) + CW'(s1.part);
    case (s1.func)
      tsau_pkg::FN_TO_MS, tsau_pkg::FN_TO_US, tsau_pkg::FN_TO_NS: begin
        w0_next.rc = full[63:0];
        w0_next.st = (|full[CW-1:64]) ? tsau_pkg::ST_OVF : tsau_pkg::ST_OK;
      end
      tsau_pkg::FN_DIV: begin
        w0_next.dvd = 64'(s1.as);
        w0_next.dvs = s1.fac;
      end
      tsau_pkg::FN_MUL: begin
        w0_next.dvd = 64'(s1.prod);
        w0_next.dvs = 32'(tsau_pkg::ONE_E9);
      end
      tsau_pkg::FN_FROM_MS: begin
        w0_next.dvd = s1.cnt;
        w0_next.dvs = 32'(tsau_pkg::ONE_E3);
      end
      tsau_pkg::FN_FROM_US: begin
        w0_next.dvd = s1.cnt;
        w0_next.dvs = 32'(tsau_pkg::ONE_E6);
      end
      tsau_pkg::FN_FROM_NS: begin
        w0_next.dvd = s1.cnt;
        w0_next.dvs = 32'(tsau_pkg::ONE_E9);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[0] <= w0_next;
    end
  end

  // First long division: 64 steps, one quotient bit each.
  for (genvar gi = 0; gi < P1; gi++) begin : g_div1
    always_ff @(posedge clk) begin
      if (adv) begin
        w[gi+1] <= work_step(w[gi]);
      end
    end
  end

  // Middle stage: remainder scaling, the div seconds and zero-divisor status, and the mul and from-count results.
  always_comb begin
    logic [29:0]   k;
    logic [29:0]   addend;
    logic [61:0]   mulv;
    logic [MW-1:0] msum;
    wm_next = w[P1];
    k       = '0;
    addend  = '0;
    case (w[P1].func)
      tsau_pkg::FN_DIV: begin
        k      = tsau_pkg::ONE_E9;
        addend = w[P1].an;
      end
      tsau_pkg::FN_FROM_MS: k = tsau_pkg::ONE_E6;
      tsau_pkg::FN_FROM_US: k = tsau_pkg::ONE_E3;
      tsau_pkg::FN_FROM_NS: k = tsau_pkg::ONE;
      default: ;
    endcase
    mulv = 62'(w[P1].rem) * 62'(k) + 62'(addend);
    msum = MW'(w[P1].asfac) + MW'(w[P1].dvd);
    case (w[P1].func)
      tsau_pkg::FN_DIV: begin
        if (w[P1].dvs == '0) begin
          wm_next.st = tsau_pkg::ST_ZDIV;
        end else begin
          wm_next.rs  = w[P1].dvd[SEC_BITS-1:0];
          wm_next.rem = mulv[61:30];
          wm_next.dvd = {mulv[29:0], 34'b0};
        end
      end
      tsau_pkg::FN_MUL: begin
        wm_next.rn = w[P1].rem[29:0];
        wm_next.rs = msum[SEC_BITS-1:0];
        wm_next.st = (|msum[MW-1:SEC_BITS]) ? tsau_pkg::ST_OVF : tsau_pkg::ST_OK;
      end
      tsau_pkg::FN_FROM_MS, tsau_pkg::FN_FROM_US, tsau_pkg::FN_FROM_NS: begin
        wm_next.rn = mulv[29:0];
        wm_next.rs = w[P1].dvd[SEC_BITS-1:0];
        wm_next.st = (|w[P1].dvd[63:SEC_BITS]) ? tsau_pkg::ST_OVF : tsau_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[IDX_M] <= wm_next;
    end
  end

  // Second long division: 30 steps give the nanosecond quotient of div.
  for (genvar gj = 0; gj < P2; gj++) begin : g_div2
    always_ff @(posedge clk) begin
      if (adv) begin
        w[IDX_M+1+gj] <= work_step(w[IDX_M+gj]);
      end
    end
  end

  always_comb begin
    wout_next = w[IDX_OUT-1];
    if (w[IDX_OUT-1].func == tsau_pkg::FN_DIV && w[IDX_OUT-1].st == tsau_pkg::ST_OK) begin
      wout_next.rn = w[IDX_OUT-1].dvd[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[IDX_OUT] <= wout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= '0;
    end else if (adv) begin
      wv <= {wv[NW-2:0], v1};
    end
  end

  assign w_out    = w[IDX_OUT];
  assign m_tvalid = wv[IDX_OUT];
  assign m_tdata  = OUT_W'({w_out.st, w_out.vd, w_out.rc, w_out.rn, w_out.rs});

  assign out_is_cmp  = w_out.func == tsau_pkg::FN_GT || w_out.func == tsau_pkg::FN_LT ||
                       w_out.func == tsau_pkg::FN_EQ;
  assign out_zero_ts = w_out.rs == '0 && w_out.rn == '0 && w_out.func == tsau_pkg::FN_DIV;

  `TSAU_ASSERT_NEXT(a_skid_keeps, clk, rst, skid_v && !adv, skid_v)
  `TSAU_ASSERT_NEXT(a_stall_to_skid, clk, rst, s_tvalid && s_tready && !adv, skid_v)
  `TSAU_ASSERT_NOW(a_zdiv_zero, clk, rst, m_tvalid && w_out.st == tsau_pkg::ST_ZDIV, out_zero_ts)
  `TSAU_ASSERT_NOW(a_verdict_cmp, clk, rst, m_tvalid && w_out.vd, out_is_cmp)
  `TSAU_ASSERT_NOW(a_nsec_range, clk, rst, m_tvalid, w_out.rn <= tsau_pkg::NS_MAX)

endmodule

// ----- verif/timespec_arithmetic_unit_test.sv -----
// Self-checking testbench for the timestamp arithmetic unit with a scoreboard class.
`timescale 1ns / 100ps

module timespec_arithmetic_unit_test;

  localparam int SEC_W = 48;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 130;
  localparam int RANDOM_ITEMS = 530;

  localparam logic [127:0] SEC_MASK = (128'd1 << SEC_W) - 1;
  localparam logic [127:0] U64_MAX = (128'd1 << 64) - 1;

  // Input word fields, listed from the highest bits down.
  typedef struct packed {
    logic [63:0] count;
    logic [31:0] factor;
    logic [29:0] b_nsec;
    logic [47:0] b_sec;
    logic [29:0] a_nsec;
    logic [47:0] a_sec;
    logic [3:0]  func;
  } op_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        verdict;
    logic [63:0] count;
    logic [29:0] nsec;
    logic [47:0] sec;
  } ts_result_t;

  class ts_scoreboard;
    ts_result_t pending_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int compare_ts(logic [47:0] as, logic [29:0] an, logic [47:0] bs,
                            logic [29:0] bn);
      if (as != bs) return (as > bs) ? 1 : -1;
      if (an != bn) return (an > bn) ? 1 : -1;
      return 0;
    endfunction

    // Timestamp to count: seconds times units per second plus whole units.
    function void ts_to_count(logic [47:0] s, logic [29:0] n, logic [127:0] per_sec,
                              logic [127:0] ns_per_unit, ref ts_result_t r);
      logic [127:0] full;
      full = s * per_sec + n / ns_per_unit;
      if (full > U64_MAX) r.status = tsau_pkg::ST_OVF;
      r.count = full[63:0];
    endfunction

    function void count_to_ts(logic [63:0] c, logic [127:0] per_sec,
                              logic [127:0] ns_per_unit, ref ts_result_t r);
      logic [127:0] q;
      logic [127:0] n;
      q = c / per_sec;
      n = (c % per_sec) * ns_per_unit;
      if (q > SEC_MASK) r.status = tsau_pkg::ST_OVF;
      r.sec = q[47:0];
      r.nsec = n[29:0];
    endfunction

    function ts_result_t predict_timespec(op_word_t w);
      ts_result_t r;
      logic [29:0] an, bn;
      logic [127:0] wide, rem, prod, carry;
      int c;
      r = '0;
      an = (w.a_nsec > tsau_pkg::NS_MAX) ? tsau_pkg::NS_MAX : w.a_nsec;
      bn = (w.b_nsec > tsau_pkg::NS_MAX) ? tsau_pkg::NS_MAX : w.b_nsec;
      c = compare_ts(w.a_sec, an, w.b_sec, bn);
      case (w.func)
        tsau_pkg::FN_GT: r.verdict = (c > 0);
        tsau_pkg::FN_LT: r.verdict = (c < 0);
        tsau_pkg::FN_EQ: r.verdict = (c == 0);
        tsau_pkg::FN_SUB: begin
          if (c < 0) r.status = tsau_pkg::ST_NEG;
          wide = {80'd0, w.a_sec} - {80'd0, w.b_sec};
          if (bn > an) begin
            wide = wide - 1;
            r.nsec = 30'(64'd1000000000 + an - bn);
          end else begin
            r.nsec = an - bn;
          end
          r.sec = wide[47:0];
        end
        tsau_pkg::FN_ADD: begin
          wide = {80'd0, w.a_sec} + {80'd0, w.b_sec};
          prod = an + bn;
          if (prod >= 128'd1000000000) begin
            wide = wide + 1;
            prod = prod - 128'd1000000000;
          end
          if (wide > SEC_MASK) r.status = tsau_pkg::ST_OVF;
          r.sec = wide[47:0];
          r.nsec = prod[29:0];
        end
        tsau_pkg::FN_DIV: begin
          if (w.factor == 0) begin
            r.status = tsau_pkg::ST_ZDIV;
          end else begin
            rem = w.a_sec % w.factor;
            wide = w.a_sec / w.factor;
            prod = (rem * 128'd1000000000 + an) / w.factor;
            r.sec = wide[47:0];
            r.nsec = prod[29:0];
          end
        end
        tsau_pkg::FN_MUL: begin
          prod = an * w.factor;
          carry = prod / 128'd1000000000;
          wide = prod % 128'd1000000000;
          r.nsec = wide[29:0];
          wide = w.a_sec * w.factor + carry;
          if (wide > SEC_MASK) r.status = tsau_pkg::ST_OVF;
          r.sec = wide[47:0];
        end
        tsau_pkg::FN_TO_MS: ts_to_count(w.a_sec, an, 1000, 1000000, r);
        tsau_pkg::FN_TO_US: ts_to_count(w.a_sec, an, 1000000, 1000, r);
        tsau_pkg::FN_TO_NS: ts_to_count(w.a_sec, an, 1000000000, 1, r);
        tsau_pkg::FN_FROM_MS: count_to_ts(w.count, 1000, 1000000, r);
        tsau_pkg::FN_FROM_US: count_to_ts(w.count, 1000000, 1000, r);
        tsau_pkg::FN_FROM_NS: count_to_ts(w.count, 1000000000, 1, r);
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_input(op_word_t w);
      pending_results.push_back(predict_timespec(w));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_output(logic [151:0] data);
      ts_result_t got, want;
      got = data[144:0];
      if (pending_results.size() == 0) begin
        report("unexpected word", got.sec, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.sec != want.sec) report("res_sec", got.sec, want.sec);
        if (got.nsec != want.nsec) report("res_nsec", got.nsec, want.nsec);
        if (got.count != want.count) report("res_count", got.count, want.count);
        if (got.verdict != want.verdict) report("verdict", got.verdict, want.verdict);
        if (got.status != want.status) report("status", got.status, want.status);
      end
      if (data[151:145] != 0) report("padding", data[151:145], 0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [255:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [151:0] m_tdata;

  ts_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  longint unsigned cycles = 0;

  timespec_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drives one word at the falling edge and holds it until accepted.
  task send_word(op_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = w;
    do @(posedge clk); while (!s_tready);
    sb.note_input(w);
  endtask

  task wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function logic [47:0] rand_sec();
    case ($urandom_range(0, 3))
      0: return 48'($urandom_range(0, 1000));
      1: return {16'hffff, 32'($urandom)} - 48'($urandom_range(0, 1000));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function logic [29:0] rand_nsec();
    if ($urandom_range(0, 99) < 15) return 30'($urandom_range(999000000, 1073741823));
    return 30'($urandom_range(0, 999999999));
  endfunction

  function op_word_t rand_word();
    op_word_t w;
    w.func = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(13, 15))
                                         : 4'($urandom_range(0, 12));
    w.a_sec = rand_sec();
    w.a_nsec = rand_nsec();
    w.b_sec = ($urandom_range(0, 3) == 0) ? w.a_sec : rand_sec();
    w.b_nsec = ($urandom_range(0, 3) == 0) ? w.a_nsec : rand_nsec();
    case ($urandom_range(0, 4))
      0: w.factor = '0;
      1: w.factor = $urandom_range(1, 20);
      default: w.factor = $urandom;
    endcase
    if ($urandom_range(0, 2) == 0) w.count = 64'($urandom);
    else w.count = {$urandom, $urandom};
    return w;
  endfunction

  function op_word_t make_word(logic [3:0] f, logic [47:0] as, logic [29:0] an,
                               logic [47:0] bs, logic [29:0] bn, logic [31:0] fac,
                               logic [63:0] cnt);
    op_word_t w;
    w.func = f;
    w.a_sec = as; w.a_nsec = an; w.b_sec = bs; w.b_nsec = bn;
    w.factor = fac; w.count = cnt;
    return w;
  endfunction

  initial begin
    logic [47:0] smax;
    logic [29:0] nmax;
    smax = '1;
    nmax = tsau_pkg::NS_MAX;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(make_word(tsau_pkg::FN_GT, 5, 10, 5, 9, 0, 0));
    send_word(make_word(tsau_pkg::FN_LT, 4, 0, 5, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_EQ, smax, 30'h3fffffff, smax, nmax, 0, 0));
    send_word(make_word(tsau_pkg::FN_GT, 7, 30'h3fffffff, 7, nmax, 0, 0));
    send_word(make_word(tsau_pkg::FN_SUB, 10, 100, 3, 200, 0, 0));
    send_word(make_word(tsau_pkg::FN_SUB, 3, 0, 10, 1, 0, 0));
    send_word(make_word(tsau_pkg::FN_SUB, 0, 0, smax, nmax, 0, 0));
    send_word(make_word(tsau_pkg::FN_ADD, smax, nmax, smax, nmax, 0, 0));
    send_word(make_word(tsau_pkg::FN_ADD, 1, 600000000, 2, 400000000, 0, 0));
    send_word(make_word(tsau_pkg::FN_DIV, smax, nmax, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_DIV, smax, nmax, 0, 0, 32'hffffffff, 0));
    send_word(make_word(tsau_pkg::FN_DIV, 7, 5, 0, 0, 3, 0));
    send_word(make_word(tsau_pkg::FN_MUL, smax, nmax, 0, 0, 32'hffffffff, 0));
    send_word(make_word(tsau_pkg::FN_MUL, smax, nmax, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_MUL, 1, 500000000, 0, 0, 2, 0));
    send_word(make_word(tsau_pkg::FN_TO_MS, smax, nmax, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_TO_US, smax, nmax, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_TO_NS, smax, nmax, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_TO_NS, 0, 1, 0, 0, 0, 0));
    send_word(make_word(tsau_pkg::FN_FROM_MS, 0, 0, 0, 0, 0, '1));
    send_word(make_word(tsau_pkg::FN_FROM_US, 0, 0, 0, 0, 0, '1));
    send_word(make_word(tsau_pkg::FN_FROM_NS, 0, 0, 0, 0, 0, '1));
    send_word(make_word(4'd13, smax, nmax, smax, nmax, '1, '1));
    send_word(make_word(4'd14, 1, 1, 1, 1, 1, 1));
    send_word(make_word(4'd15, 0, 0, 0, 0, 0, 0));

    // Hold the sender off until the pipeline has emptied, then run the stall phases.
    wait_drained();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_word(rand_word());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tsau_pkg.sv
sv/timespec_arithmetic_unit.sv
verif/timespec_arithmetic_unit_test.sv
